// ===== rtl/orp_pkg.sv =====
// Shared types and constants for the oldest-first retention picker.
`default_nettype none

package orp_pkg;

   // Fixed field widths of the transfer payloads.
   localparam int SIZE_W       = 32;
   localparam int DROP_INDEX_W = 4;
   localparam int DROP_TOTAL_W = 5;

   // Most results one decision may report.
   localparam int MAX_RESULTS = 15;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_CAP   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_LIMIT = 1'd1;

   // Configuration reset values.
   localparam logic [SIZE_W-1:0]       BYTE_CAP_RESET   = 32'hFFFF_FFFF;
   localparam logic [DROP_TOTAL_W-1:0] DROP_LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [SIZE_W-1:0] file_size;
      logic              entry_present;
      logic              end_of_list;
      logic [SIZE_W-1:0] incoming_size;
   } orp_req_type;

   typedef struct packed {
      logic [DROP_INDEX_W-1:0] drop_index;
      logic                    drop_valid;
      logic                    run_last;
      logic [DROP_TOTAL_W-1:0] drop_total;
   } orp_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/orp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module orp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/orp_front.sv =====
// Front end: stores entry sizes, keeps the running total and posts finished lists.
`default_nettype none

module orp_front
   import orp_pkg::*;
#(
   parameter int MAX_FILES = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       accept,
   input  wire orp_req_type                                req_data,
   output      logic                                       wr_en,
   output      logic [$clog2(MAX_FILES):0]                 wr_addr,
   output      logic [SIZE_W-1:0]                          wr_data,
   output      logic                                       push,
   output      logic [$clog2(MAX_FILES+1)*2+SIZE_W:0]      push_data
);

   localparam int IDX_W   = $clog2(MAX_FILES);
   localparam int CNT_W   = $clog2(MAX_FILES + 1);
   localparam int TOTAL_W = SIZE_W + CNT_W;

   logic               bank_ff, bank_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               store;
   logic [CNT_W-1:0]   count_add;
   logic [TOTAL_W-1:0] total_add;

   // Entries past the list capacity are dropped on the floor.
   assign store     = accept && req_data.entry_present && (count_ff < CNT_W'(MAX_FILES));
   assign count_add = store ? count_ff + CNT_W'(1) : count_ff;
   assign total_add = store ? total_ff + TOTAL_W'(req_data.file_size) : total_ff;

   assign wr_en   = store;
   assign wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign wr_data = req_data.file_size;

   assign push      = accept && req_data.end_of_list;
   assign push_data = {bank_ff, count_add, total_add + TOTAL_W'(req_data.incoming_size)};

   always_comb begin
      bank_in  = bank_ff;
      count_in = count_add;
      total_in = total_add;
      if (push) begin
         bank_in  = ~bank_ff;
         count_in = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/orp_queue.sv =====
// Two-entry queue of finished lists between the front and back ends.
`default_nettype none

module orp_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output      logic [DATA_W-1:0] head_data,
   output      logic              empty,
   output      logic              full
);

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign empty     = (fill_ff == 2'd0);
   assign full      = (fill_ff == 2'(DEPTH));
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/orp_back.sv =====
// Back end: walks a finished list from the oldest entry and reports the drops, or one "no drop" result.
`default_nettype none

module orp_back
   import orp_pkg::*;
#(
   parameter int MAX_FILES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  empty,
   input  wire logic [$clog2(MAX_FILES+1)*2+SIZE_W:0] head_data,
   output      logic                                  pop,
   input  wire logic [SIZE_W-1:0]                     byte_cap,
   input  wire logic [DROP_TOTAL_W-1:0]               drop_limit,
   output      logic [$clog2(MAX_FILES):0]            rd_addr,
   input  wire logic [SIZE_W-1:0]                     rd_data,
   output      logic                                  rsp_valid,
   output      orp_rsp_type                           rsp_data
);

   localparam int IDX_W   = $clog2(MAX_FILES);
   localparam int CNT_W   = $clog2(MAX_FILES + 1);
   localparam int TOTAL_W = SIZE_W + CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic                    bank_ff, bank_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [DROP_TOTAL_W-1:0] n_ff, n_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   orp_rsp_type             rsp_data_ff, rsp_data_in;

   logic [TOTAL_W-1:0]      cap_ext;
   logic [TOTAL_W-1:0]      new_total;
   logic [DROP_TOTAL_W-1:0] n_next;
   logic [IDX_W-1:0]        idx_next;
   logic [CNT_W-1:0]        idx_plus2;
   logic [31:0]             idx_wide;
   logic                    first_go;
   logic                    more;

   assign cap_ext   = TOTAL_W'(byte_cap);
   assign new_total = total_ff - TOTAL_W'(rd_data);
   assign n_next    = n_ff + DROP_TOTAL_W'(1);
   assign idx_next  = idx_ff + IDX_W'(1);
   assign idx_plus2 = CNT_W'(idx_ff) + CNT_W'(2);
   assign idx_wide  = 32'(idx_ff);

   // The newest entry is never a candidate, so at least two entries are needed.
   assign first_go = (count_ff > CNT_W'(1)) && (total_ff > cap_ext) &&
                     (drop_limit != '0);

   // Whether the walk goes on past the entry that this step reports as dropped.
   assign more = (idx_plus2 < count_ff) && (new_total > cap_ext) &&
                 (n_next < drop_limit) && (n_next < DROP_TOTAL_W'(MAX_RESULTS));

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      rd_addr      = {bank_ff, idx_ff};
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               {bank_in, count_in, total_in} = head_data;
               idx_in   = '0;
               n_in     = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (first_go) begin
               state_in = ST_STEP;
            end else begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.drop_index = '0;
               rsp_data_in.drop_valid = 1'b0;
               rsp_data_in.run_last   = 1'b1;
               rsp_data_in.drop_total = '0;
               pop                    = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         ST_STEP: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.drop_index = idx_wide[DROP_INDEX_W-1:0];
            rsp_data_in.drop_valid = 1'b1;
            rsp_data_in.run_last   = ~more;
            rsp_data_in.drop_total = n_next;
            total_in               = new_total;
            n_in                   = n_next;
            if (more) begin
               idx_in  = idx_next;
               rd_addr = {bank_ff, idx_next};
            end else begin
               pop      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      count_ff    <= count_in;
      total_ff    <= total_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/oldest_first_retention_picker.sv =====
// Top level of the oldest-first retention picker: front end, list queue, walker and RAM.
// The walker takes a finished list from the queue, evaluates it and then issues either
// its single "no drop" result or its drops, one drop per cycle until the decision ends.
// The front end takes one list entry per cycle while busy is low; the back end reads one
// stored size per cycle from the RAM read port as it walks, one list at a time.
// Reset clears the list, the queue and the walker; byte_cap and drop_limit return to
// all ones and 16. Results cannot be held off by the receiver.
`default_nettype none

module oldest_first_retention_picker
   import orp_pkg::*;
#(
   parameter int MAX_FILES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire orp_req_type            req_data,
   output      logic                   rsp_valid,
   output      orp_rsp_type            rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]      csr_wdata
);

   localparam int IDX_W   = $clog2(MAX_FILES);
   localparam int CNT_W   = $clog2(MAX_FILES + 1);
   localparam int TOTAL_W = SIZE_W + CNT_W;
   localparam int DESC_W  = 1 + CNT_W + TOTAL_W;
   localparam int ADDR_W  = IDX_W + 1;

   // Configuration registers.
   logic [SIZE_W-1:0]       byte_cap_ff, byte_cap_in;
   logic [DROP_TOTAL_W-1:0] drop_limit_ff, drop_limit_in;

   logic              accept;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SIZE_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [SIZE_W-1:0] rd_data;
   logic              push;
   logic [DESC_W-1:0] push_data;
   logic              pop;
   logic [DESC_W-1:0] head_data;
   logic              q_empty;
   logic              q_full;

   // The RAM holds two banks of MAX_FILES sizes. Each list goes to the bank opposite the
   // previous one, so the front end fills the next list while the back end walks this one.
   // Up to two finished lists may wait; with both queue slots taken, both banks are in
   // use and the block reports busy until the walk of the older one completes.
   assign busy   = q_full;
   assign accept = start && !busy;

   always_comb begin
      byte_cap_in   = byte_cap_ff;
      drop_limit_in = drop_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BYTE_CAP:   byte_cap_in   = csr_wdata;
            CSR_DROP_LIMIT: drop_limit_in = csr_wdata[DROP_TOTAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cap_ff   <= BYTE_CAP_RESET;
         drop_limit_ff <= DROP_LIMIT_RESET;
      end else begin
         byte_cap_ff   <= byte_cap_in;
         drop_limit_ff <= drop_limit_in;
      end
   end

   // The front end takes one item per transfer, stores the size and posts a finished list.
   orp_front #(
      .MAX_FILES (MAX_FILES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   // Each queue slot carries the bank, the entry count and the total with incoming bytes.
   orp_queue #(
      .DATA_W (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   orp_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (2 ** ADDR_W)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The back end releases a queue slot once the last result of its decision is issued.
   orp_back #(
      .MAX_FILES (MAX_FILES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head_data  (head_data),
      .pop        (pop),
      .byte_cap   (byte_cap_ff),
      .drop_limit (drop_limit_ff),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the oldest-first retention picker: directed and random lists against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import orp_pkg::*;

   // List depth of the block under test; the predictor uses the same bound.
   localparam int LIST_DEPTH = 16;

   // Cycles to let pass once the last expected result has come. A decision reports at most
   // 15 drops after its final item, so this is ample.
   localparam int SETTLE_CYCLES = 40;

   // Bound on how long a phase waits for outstanding results before calling them lost.
   localparam int DRAIN_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   orp_req_type            req_data = '0;
   logic                   rsp_valid;
   orp_rsp_type            rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]      csr_wdata = '0;

   oldest_first_retention_picker #(
      .MAX_FILES(LIST_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // The clock runs with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // List items waiting to be offered, and drop decisions waiting to come out of the block.
   orp_req_type list_items [$];
   orp_rsp_type pending_picks [$];

   // Predictor copy of the block's state and registers.
   logic [SIZE_W-1:0]       held_size [LIST_DEPTH];
   int                      held_count;
   logic [63:0]             held_sum;
   logic [SIZE_W-1:0]       model_cap;
   logic [DROP_TOTAL_W-1:0] limit_drops;

   // Run bookkeeping.
   int  error_count = 0;
   int  items_taken = 0;
   int  decisions_seen = 0;
   int  drops_seen = 0;
   int  settings_used = 0;
   bit  req_taken = 1'b0;
   bit  no_gaps = 1'b0;
   int  gap_cnt = 0;

   // Every mismatch goes through here so that it prints once and is counted.
   task automatic flag_error(input string msg);
      error_count++;
      $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   // Applies one accepted list item to the predictor. A final item closes the list, and the
   // walk runs from the oldest entry, never touching the newest one, until the stored files
   // plus the incoming bytes fit the byte cap or the drop limit or the result bound is hit.
   task automatic predict_drops(input orp_req_type it);
      logic [63:0] remaining;
      orp_rsp_type run [MAX_RESULTS];
      orp_rsp_type one;
      int n;
      int i;
      int k;
      // Entries beyond the list depth are dropped on the floor: neither stored nor summed.
      if (it.entry_present && held_count < LIST_DEPTH) begin
         held_size[held_count] = it.file_size;
         held_count++;
         held_sum += 64'(it.file_size);
      end
      if (it.end_of_list) begin
         remaining = held_sum + 64'(it.incoming_size);
         n = 0;
         i = 0;
         while (i + 1 < held_count && remaining > 64'(model_cap) &&
                n < int'(limit_drops) && n < MAX_RESULTS) begin
            run[n].drop_index = DROP_INDEX_W'(i);
            run[n].drop_valid = 1'b1;
            run[n].run_last   = 1'b0;
            run[n].drop_total = DROP_TOTAL_W'(n + 1);
            remaining -= 64'(held_size[i]);
            n++;
            i++;
         end
         if (n == 0) begin
            // Nothing to drop still yields one result, flagged as the last one.
            one = '0;
            one.run_last = 1'b1;
            pending_picks.push_back(one);
         end else begin
            for (k = 0; k < n; k++) begin
               one = run[k];
               one.run_last = (k == n - 1);
               pending_picks.push_back(one);
            end
         end
         held_count = 0;
         held_sum   = '0;
      end
   endtask

   // Monitor: everything is sampled at the rising edge, where the testbench's own inputs are
   // stable because they only change on the falling edge.
   always @(posedge clock) begin
      orp_rsp_type want;
      if (reset) begin
         held_count  = 0;
         held_sum    = '0;
         model_cap   = BYTE_CAP_RESET;
         limit_drops = DROP_LIMIT_RESET;
         req_taken  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BYTE_CAP: begin
                  model_cap = csr_wdata;
               end
               CSR_DROP_LIMIT: begin
                  limit_drops = csr_wdata[DROP_TOTAL_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            items_taken++;
            predict_drops(req_data);
         end
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (pending_picks.size() == 0) begin
               flag_error($sformatf("result with nothing expected: %p", rsp_data));
            end else begin
               want = pending_picks.pop_front();
               if (rsp_data.drop_index !== want.drop_index) begin
                  flag_error($sformatf("drop_index %0d, expected %0d",
                                       rsp_data.drop_index, want.drop_index));
               end
               if (rsp_data.drop_valid !== want.drop_valid) begin
                  flag_error($sformatf("drop_valid %0b, expected %0b",
                                       rsp_data.drop_valid, want.drop_valid));
               end
               if (rsp_data.run_last !== want.run_last) begin
                  flag_error($sformatf("run_last %0b, expected %0b",
                                       rsp_data.run_last, want.run_last));
               end
               if (rsp_data.drop_total !== want.drop_total) begin
                  flag_error($sformatf("drop_total %0d, expected %0d",
                                       rsp_data.drop_total, want.drop_total));
               end
               if (want.run_last) begin
                  decisions_seen++;
               end
               if (want.drop_valid) begin
                  drops_seen++;
               end
            end
         end
      end
   end

   // Driver: works on the falling edge. An offered item stays on the port until a transfer
   // took it; only then may a new one follow or an idle burst begin. Each signal gets one
   // assignment per edge, so start is never lowered and raised in the same step.
   always @(negedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         gap_cnt <= 0;
      end else if (!(start && !req_taken)) begin
         if (gap_cnt > 0) begin
            start   <= 1'b0;
            gap_cnt <= gap_cnt - 1;
         end else if (list_items.size() != 0 && !no_gaps && $urandom_range(0, 5) == 0) begin
            // An idle burst begins here; gap_cnt holds the rest of it.
            start   <= 1'b0;
            gap_cnt <= $urandom_range(1, 18) - 1;
         end else if (list_items.size() != 0) begin
            start    <= 1'b1;
            req_data <= list_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void add_item(input logic [SIZE_W-1:0] size, input bit present,
                                    input bit last, input logic [SIZE_W-1:0] incoming);
      orp_req_type it;
      it.file_size     = size;
      it.entry_present = present;
      it.end_of_list   = last;
      it.incoming_size = incoming;
      list_items.push_back(it);
   endfunction

   // Most sizes stay near the scale of the phase so that the cap really bites; a few are
   // drawn over the full 32 bits.
   function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] size_hi);
      if ($urandom_range(0, 9) == 0) begin
         return $urandom;
      end
      return $urandom_range(0, size_hi);
   endfunction

   // Queues one list: mostly short lists, sometimes an empty one, sometimes one that runs
   // past the list depth. A few entries are placeholders without a file, and the final item
   // carries an entry about half the time. Returns the number of items queued.
   function automatic int queue_random_list(input logic [SIZE_W-1:0] size_hi);
      int len;
      int k;
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 3);
         default: len = $urandom_range(1, 7);
      endcase
      for (k = 0; k < len; k++) begin
         add_item(pick_size(size_hi), $urandom_range(0, 9) != 0, 1'b0, $urandom);
      end
      add_item(pick_size(size_hi), 1'($urandom_range(0, 1)), 1'b1,
               ($urandom_range(0, 3) == 0) ? 32'($urandom) : pick_size(size_hi));
      return len + 1;
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Loads both registers; called only while the block holds no work.
   task automatic set_registers(input logic [SIZE_W-1:0] cap, input logic [SIZE_W-1:0] limit);
      csr_write(CSR_BYTE_CAP, cap);
      csr_write(CSR_DROP_LIMIT, limit);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Waits until every queued item has been transferred and every expected result has come,
   // then lets the walker settle. Results that never show up are reported here.
   task automatic drain_picks();
      int waited;
      waited = 0;
      while (list_items.size() != 0 || start) begin
         @(posedge clock);
      end
      while (pending_picks.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_picks.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived", pending_picks.size()));
         pending_picks.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase under one register setting. The limit word carries random upper bits,
   // which the block must ignore.
   task automatic run_phase(input logic [SIZE_W-1:0] cap, input logic [DROP_TOTAL_W-1:0] limit,
                            input logic [SIZE_W-1:0] size_hi, input int target,
                            input bit quiet);
      int queued;
      logic [SIZE_W-1:0] limit_word;
      queued     = 0;
      limit_word = $urandom;
      limit_word[DROP_TOTAL_W-1:0] = limit;
      set_registers(cap, limit_word);
      no_gaps = quiet;
      while (queued < target) begin
         queued += queue_random_list(size_hi);
      end
      drain_picks();
   endtask

   // Main sequence: one reset, a directed phase, then random phases under several settings,
   // extremes included. The last phase runs with the sender never idling.
   initial begin
      int k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // Directed part with a cap of 1000 bytes.
      set_registers(32'd1000, 32'd16);
      // Empty list: the final item carries no entry, so nothing can go.
      add_item(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
      // A single oversized entry is the newest one and is kept.
      add_item(32'd5000, 1'b1, 1'b1, 32'd0);
      // Three entries plus incoming bytes over the cap: the oldest goes.
      add_item(32'd400, 1'b1, 1'b0, 32'hFFFF_FFFF);
      add_item(32'd400, 1'b1, 1'b0, 32'd0);
      add_item(32'd400, 1'b1, 1'b1, 32'd100);
      // The final item brings its own entry, which counts as the newest.
      add_item(32'd600, 1'b1, 1'b0, 32'd0);
      add_item(32'd600, 1'b1, 1'b1, 32'd0);
      // Overflowing list: seventeen entries with full-scale sizes at both ends; the last
      // one lies beyond the list depth and must be ignored.
      add_item(32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0);
      for (k = 1; k < LIST_DEPTH; k++) begin
         add_item((k % 2 == 0) ? 32'd0 : 32'd50, 1'b1, 1'b0, 32'h5555_AAAA);
      end
      add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      drain_picks();

      // A zero cap drops everything but the newest, up to the result bound.
      run_phase(32'd0, 5'd16, 32'd1000, 30, 1'b0);
      // A zero drop limit never drops.
      run_phase(32'd0, 5'd0, 32'd1000, 15, 1'b0);
      // Full cap with the largest limit code: only huge totals drop anything.
      run_phase(32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 30, 1'b0);
      begin
         logic [SIZE_W-1:0] cap;
         cap = $urandom_range(2000, 60000);
         run_phase(cap, DROP_TOTAL_W'($urandom_range(1, 5)), cap / 3, 30, 1'b0);
      end
      run_phase($urandom, DROP_TOTAL_W'($urandom_range(0, 31)), $urandom, 30, 1'b0);
      run_phase($urandom_range(500, 5000), 5'd16, 32'd1500, 30, 1'b1);

      $display("Covered %0d list items in %0d decisions with %0d drops reported,",
               items_taken, decisions_seen, drops_seen);
      $display("under %0d register settings.", settings_used);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("Run timed out.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
